// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/vsd_pkg.sv
// ----------------------------------------------------------------------------
// vsd_pkg
// Types, register codes and width tables for the septet varint decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vsd_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 6;
  localparam int VALUE_W    = 64;

  localparam logic [3:0] COUNT_LIMIT = 4'd11;
  localparam logic [3:0] MERGE_LIMIT = 4'd10;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WIDTH_MODE = 2'd0,
    REG_POST_MODE  = 2'd1,
    REG_SEQ_BITS   = 2'd2,
    REG_SEQ_SHIFT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_32 = 2'd2,
    WIDTH_64 = 2'd3
  } width_t;

  typedef enum logic [1:0] {
    POST_NONE = 2'd0,
    POST_SEQ  = 2'd1,
    POST_ID   = 2'd2
  } post_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  function automatic logic [VALUE_W-1:0] width_mask(input width_t w);
    logic [VALUE_W-1:0] m;
    case (w)
      WIDTH_8:  m = {{56{1'b0}}, {8{1'b1}}};
      WIDTH_16: m = {{48{1'b0}}, {16{1'b1}}};
      WIDTH_32: m = {{32{1'b0}}, {32{1'b1}}};
      default:  m = {VALUE_W{1'b1}};
    endcase
    return m;
  endfunction

  // Number of bytes that can encode a W-bit value: ceil(W/7).
  function automatic logic [3:0] max_bytes(input width_t w);
    logic [3:0] n;
    case (w)
      WIDTH_8:  n = 4'd2;
      WIDTH_16: n = 4'd3;
      WIDTH_32: n = 4'd5;
      default:  n = 4'd10;
    endcase
    return n;
  endfunction

  // Bits the last allowed byte may carry: W mod 7.
  function automatic logic [2:0] extra_bits(input width_t w);
    logic [2:0] e;
    case (w)
      WIDTH_8:  e = 3'd1;
      WIDTH_16: e = 3'd2;
      WIDTH_32: e = 3'd4;
      default:  e = 3'd1;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// File: sv/varint_septet_decoder_unit.sv
// ----------------------------------------------------------------------------
// varint_septet_decoder_unit
// Streaming decoder for little-endian 7-bit-group unsigned varints.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while input ready is high: a data
// byte or an end-of-buffer marker. Each data byte is merged into the
// accumulator in the cycle it is accepted; a terminating byte or an
// end-of-buffer marker writes its result into a registered two-entry output
// buffer, so the sustained rate is one byte per clock. Input ready drops only
// when both output entries are full. Configuration writes take effect on the
// next request and must be made while the block is idle.
`default_nettype none

module varint_septet_decoder_unit (
  input  wire  logic                          clk,
  input  wire  logic                          rst_n,
  // Input stream.
  input  wire  logic                          in_tvalid,
  output       logic                          in_tready,
  input  wire  logic [7:0]                    in_tdata,   // [7:0] byte_in
  input  wire  logic                          in_tuser,   // [0] kind
  // Result stream.
  output       logic                          out_tvalid,
  input  wire  logic                          out_tready,
  output       logic [vsd_pkg::VALUE_W-1:0]   out_tdata,  // [63:0] value
  output       logic [1:0]                    out_tuser,  // [1:0] status
  // Configuration write port.
  input  wire  logic                          cfg_we,
  input  wire  logic [vsd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire  logic [vsd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int W = vsd_pkg::VALUE_W;

  // Configuration registers.
  vsd_pkg::width_t width_mode_r;
  vsd_pkg::post_t  post_mode_r;
  logic [5:0]      seq_bits_r;
  logic [5:0]      seq_shift_r;

  // Decoder state.
  logic [W-1:0] acc_r, acc_nxt;
  logic [3:0]   count_r, count_nxt;

  // Output buffer: head entry and skid entry.
  logic              out_valid_r, out_valid_nxt;
  logic [W-1:0]      out_value_r, out_value_nxt;
  vsd_pkg::status_t  out_status_r, out_status_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic [W-1:0]      skid_value_r, skid_value_nxt;
  vsd_pkg::status_t  skid_status_r, skid_status_nxt;

  // Datapath signals.
  logic              in_accept;
  logic              pop;
  logic [6:0]        septet;
  logic [6:0]        shift_prod;
  logic [W-1:0]      merged;
  logic [4:0]        nbytes;
  logic [4:0]        limit;
  logic [2:0]        extra;
  logic              width_ovf;
  logic [W-1:0]      mask;
  logic [W-1:0]      val;
  logic [W-1:0]      high_bits;
  logic              has_result;
  logic [W-1:0]      res_value;
  vsd_pkg::status_t  res_status;

  assign in_tready  = !skid_valid_r;
  assign in_accept  = in_tvalid && in_tready;
  assign pop        = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_mode_r <= vsd_pkg::WIDTH_32;
      post_mode_r  <= vsd_pkg::POST_NONE;
      seq_bits_r   <= 6'd28;
      seq_shift_r  <= 6'd0;
    end else if (cfg_we) begin
      case (vsd_pkg::cfg_reg_t'(cfg_addr))
        vsd_pkg::REG_WIDTH_MODE: width_mode_r <= vsd_pkg::width_t'(cfg_wdata[1:0]);
        vsd_pkg::REG_POST_MODE:  post_mode_r  <= vsd_pkg::post_t'(cfg_wdata[1:0]);
        vsd_pkg::REG_SEQ_BITS:   seq_bits_r   <= cfg_wdata;
        vsd_pkg::REG_SEQ_SHIFT:  seq_shift_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    septet     = in_tdata[6:0];
    shift_prod = {3'b000, count_r} * 7'd7;
    // Groups past the tenth byte fall beyond bit 63 and are dropped.
    merged     = acc_r;
    if (count_r < vsd_pkg::MERGE_LIMIT) begin
      merged = acc_r | ({{(W-7){1'b0}}, septet} << shift_prod[5:0]);
    end

    nbytes = {1'b0, count_r} + 5'd1;
    limit  = {1'b0, vsd_pkg::max_bytes(width_mode_r)};
    extra  = vsd_pkg::extra_bits(width_mode_r);
    if (nbytes < limit) begin
      width_ovf = 1'b0;
    end else if (nbytes == limit) begin
      width_ovf = (extra != 3'd0) && ((septet >> extra) != 7'd0);
    end else begin
      width_ovf = 1'b1;
    end

    mask      = vsd_pkg::width_mask(width_mode_r);
    val       = merged & mask;
    high_bits = {W{1'b1}} << seq_bits_r;

    res_value  = val;
    res_status = width_ovf ? vsd_pkg::STATUS_OVERFLOW : vsd_pkg::STATUS_OK;
    if (!width_ovf) begin
      case (post_mode_r)
        vsd_pkg::POST_SEQ: begin
          if ((val & high_bits) != '0) begin
            res_status = vsd_pkg::STATUS_OVERFLOW;
          end else begin
            res_value = (val << seq_shift_r) & mask;
          end
        end
        vsd_pkg::POST_ID: res_value = val >> 1;
        default: begin
        end
      endcase
    end

    acc_nxt    = acc_r;
    count_nxt  = count_r;
    has_result = 1'b0;
    if (in_accept) begin
      if (in_tuser) begin
        acc_nxt    = '0;
        count_nxt  = '0;
        has_result = 1'b1;
        res_value  = '0;
        res_status = vsd_pkg::STATUS_SHORT;
      end else if (in_tdata[7]) begin
        acc_nxt = merged;
        if (count_r < vsd_pkg::COUNT_LIMIT) begin
          count_nxt = count_r + 4'd1;
        end
      end else begin
        acc_nxt    = '0;
        count_nxt  = '0;
        has_result = 1'b1;
      end
    end
  end

  // A new result goes to the head entry unless the head is occupied and not
  // leaving this cycle; then it parks in the skid entry.
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_value_nxt   = out_value_r;
    out_status_nxt  = out_status_r;
    skid_valid_nxt  = skid_valid_r;
    skid_value_nxt  = skid_value_r;
    skid_status_nxt = skid_status_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_value_nxt  = skid_value_r;
        out_status_nxt = skid_status_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (has_result) begin
      if (out_valid_r && !pop) begin
        skid_valid_nxt  = 1'b1;
        skid_value_nxt  = res_value;
        skid_status_nxt = res_status;
      end else begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = res_value;
        out_status_nxt = res_status;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      acc_r        <= acc_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r   <= out_value_nxt;
    out_status_r  <= out_status_nxt;
    skid_value_r  <= skid_value_nxt;
    skid_status_r <= skid_status_nxt;
  end

endmodule

`default_nettype wire

// File: sv/vsd_checker.sv
// ----------------------------------------------------------------------------
// vsd_checker
// Port-level checks for the septet varint decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vsd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [7:0]                     in_tdata,
  input wire logic                           in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [vsd_pkg::VALUE_W-1:0]    out_tdata,
  input wire logic [1:0]                     out_tuser
);

  logic in_acc;
  logic out_free;
  logic out_stall;
  logic eob_acc;
  logic term_acc;
  logic is_short;
  logic short_zero;

  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid || out_tready;
  assign out_stall  = out_tvalid && !out_tready;
  assign eob_acc    = in_acc && in_tuser && out_free;
  assign term_acc   = in_acc && !in_tuser && !in_tdata[7] && out_free;
  assign is_short   = (out_tuser == vsd_pkg::STATUS_SHORT);
  assign short_zero = is_short && (out_tdata == '0);

  // A stalled result must hold its payload.
  `ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // An end-of-buffer request with room downstream shows a short result next cycle.
  `ASSERT_NEXT(a_eob_short, eob_acc, out_tvalid && short_zero)

  // A terminating data byte with room downstream gives a result next cycle.
  `ASSERT_NEXT(a_term_result, term_acc, out_tvalid)

  // A short result always carries a zero value.
  `ASSERT_SAME(a_short_zero, out_tvalid && is_short, out_tdata == '0)

endmodule

bind varint_septet_decoder_unit vsd_checker u_vsd_checker (.*);

`default_nettype wire
